// ----- rtl/core/smu_pkg.sv -----
// Package with payload types, register codes and constants of the SFBC combining unit.
package smu_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int LANE_SAT_BITS = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

    localparam logic [1:0] ANT_TWO = 2'd2;

    localparam logic [0:0] REG_TX_ANT = 1'b0;
    localparam logic [0:0] REG_RX_ANT = 1'b1;

    localparam int SUM_W  = 35;   // sum of up to four 16x16 signed products
    localparam int POW_W  = 17;
    localparam int RECIP_W = 31;  // floor(2^30 / P), P >= 1
    localparam int PROD_W = SUM_W + RECIP_W + 1;
    localparam int TERM_W = PROD_W - 33;
    localparam int DIV_STEPS = 31;

    localparam logic signed [17:0] SAT_HI = 18'sd1 <<< (LANE_SAT_BITS - 1);

    typedef struct packed {
        logic [63:0] rx0_pair;
        logic [63:0] rx1_pair;
        logic [63:0] ch_r0_t0_pair;
        logic [63:0] ch_r0_t1_pair;
        logic [63:0] ch_r1_t0_pair;
        logic [63:0] ch_r1_t1_pair;
        logic [63:0] power_words;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_k0;
        logic [31:0] out_k1;
        logic        recip_fault;
    } t_out_item;

    // Saturate a lane sum to the signed output range, keep 16 bits.
    function automatic logic [15:0] sat_lane(input logic signed [TERM_W:0] v);
        logic signed [TERM_W:0] hi;
        logic signed [TERM_W:0] lo;
        logic [15:0]            res;
        hi = (TERM_W+1)'(SAT_HI) - (TERM_W+1)'(1);
        lo = -hi - (TERM_W+1)'(1);
        if (v > hi) begin
            res = hi[15:0];
        end else if (v < lo) begin
            res = lo[15:0];
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/sfbc_mrc_unprecoder_unit.sv -----
// Top level of the SFBC / MRC combining unit: product pipeline, reciprocal pipeline, scaling.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | i_data  (smu_pkg::t_in_item)
//  out     | output    | o_valid / i_stall  | o_data  (smu_pkg::t_out_item)
//  apb     | input     | psel/penable/pready| tx_antennas @0, rx_antennas @4
//
// One item per cycle is accepted unless o_stall is high; each item passes 37 register stages.
// The depth is set by the reciprocal, a 31-step restoring divider with one
// quotient bit per pipeline stage; input, product, sum, scale, round and output add six more stages.
// A stall freezes the whole pipeline; the input is stalled only while the output
// stage holds an item that the sink does not take. Reset clears valid bits and
// the antenna registers (both to one).
module sfbc_mrc_unprecoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  smu_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output smu_pkg::t_out_item   o_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DEPTH = smu_pkg::DIV_STEPS + 6;
    localparam int SW = smu_pkg::SUM_W;
    localparam int RW = smu_pkg::RECIP_W;

    logic [1:0] r_tx_ant;
    logic [1:0] r_rx_ant;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_ant <= 2'd1;
            r_rx_ant <= 2'd1;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == smu_pkg::REG_TX_ANT) begin
                r_tx_ant <= pwdata[1:0];
            end else begin
                r_rx_ant <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == smu_pkg::REG_TX_ANT) begin
            prdata[1:0] = r_tx_ant;
        end else begin
            prdata[1:0] = r_rx_ant;
        end
    end

    logic w_adv;
    logic [DEPTH-1:0] r_vld;

    assign w_adv   = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // Stage 0: register lanes, mode flags and power sums.
    logic signed [15:0] r_a [2][2];  // [rx][re/im] symbol k0
    logic signed [15:0] r_b [2][2];
    logic signed [15:0] r_c [2][2];
    logic signed [15:0] r_f [2][2];
    logic signed [15:0] r_e [2][2];
    logic signed [15:0] r_d [2][2];
    logic [smu_pkg::POW_W-1:0] r_p0, r_p1;
    logic r_alam, r_two;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a[0][0] <= i_data.rx0_pair[63:48];       r_a[0][1] <= i_data.rx0_pair[47:32];
            r_b[0][0] <= i_data.rx0_pair[31:16];       r_b[0][1] <= i_data.rx0_pair[15:0];
            r_a[1][0] <= i_data.rx1_pair[63:48];       r_a[1][1] <= i_data.rx1_pair[47:32];
            r_b[1][0] <= i_data.rx1_pair[31:16];       r_b[1][1] <= i_data.rx1_pair[15:0];
            r_c[0][0] <= i_data.ch_r0_t0_pair[63:48];  r_c[0][1] <= i_data.ch_r0_t0_pair[47:32];
            r_f[0][0] <= i_data.ch_r0_t0_pair[31:16];  r_f[0][1] <= i_data.ch_r0_t0_pair[15:0];
            r_e[0][0] <= i_data.ch_r0_t1_pair[63:48];  r_e[0][1] <= i_data.ch_r0_t1_pair[47:32];
            r_d[0][0] <= i_data.ch_r0_t1_pair[31:16];  r_d[0][1] <= i_data.ch_r0_t1_pair[15:0];
            r_c[1][0] <= i_data.ch_r1_t0_pair[63:48];  r_c[1][1] <= i_data.ch_r1_t0_pair[47:32];
            r_f[1][0] <= i_data.ch_r1_t0_pair[31:16];  r_f[1][1] <= i_data.ch_r1_t0_pair[15:0];
            r_e[1][0] <= i_data.ch_r1_t1_pair[63:48];  r_e[1][1] <= i_data.ch_r1_t1_pair[47:32];
            r_d[1][0] <= i_data.ch_r1_t1_pair[31:16];  r_d[1][1] <= i_data.ch_r1_t1_pair[15:0];
            r_alam <= (r_tx_ant == smu_pkg::ANT_TWO);
            r_two  <= (r_rx_ant == smu_pkg::ANT_TWO);
            if (r_rx_ant == smu_pkg::ANT_TWO) begin
                r_p0 <= {1'b0, i_data.power_words[63:48]} + {1'b0, i_data.power_words[31:16]};
                r_p1 <= {1'b0, i_data.power_words[47:32]} + {1'b0, i_data.power_words[15:0]};
            end else begin
                r_p0 <= {1'b0, i_data.power_words[63:48]};
                r_p1 <= {1'b0, i_data.power_words[47:32]};
            end
        end
    end

    // Stage 1: all 32 products, with unused ones forced to zero; a zero power flags a fault and is replaced by one.
    // Index: [rx][sum 0..3 = s00,s11,s01,s10][re/im][term 0/1]
    logic signed [31:0] r_prod [2][4][2][2];
    logic               r_fault1;
    logic [smu_pkg::POW_W-1:0] r_p0_1, r_p1_1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 2; r++) begin
                logic use_r;
                logic use_a;
                use_r = (r == 0) || r_two;
                use_a = use_r && r_alam;
                r_prod[r][0][0][0] <= use_r ? r_a[r][0] * r_c[r][0] : 32'sd0;
                r_prod[r][0][0][1] <= use_r ? r_a[r][1] * r_c[r][1] : 32'sd0;
                r_prod[r][0][1][0] <= use_r ? r_a[r][1] * r_c[r][0] : 32'sd0;
                r_prod[r][0][1][1] <= use_r ? -(r_a[r][0] * r_c[r][1]) : 32'sd0;
                r_prod[r][1][0][0] <= use_r ? r_b[r][0] * r_f[r][0] : 32'sd0;
                r_prod[r][1][0][1] <= use_r ? r_b[r][1] * r_f[r][1] : 32'sd0;
                r_prod[r][1][1][0] <= use_r ? r_b[r][1] * r_f[r][0] : 32'sd0;
                r_prod[r][1][1][1] <= use_r ? -(r_b[r][0] * r_f[r][1]) : 32'sd0;
                r_prod[r][2][0][0] <= use_a ? r_b[r][0] * r_d[r][0] : 32'sd0;
                r_prod[r][2][0][1] <= use_a ? r_b[r][1] * r_d[r][1] : 32'sd0;
                r_prod[r][2][1][0] <= use_a ? r_b[r][0] * r_d[r][1] : 32'sd0;
                r_prod[r][2][1][1] <= use_a ? -(r_b[r][1] * r_d[r][0]) : 32'sd0;
                r_prod[r][3][0][0] <= use_a ? -(r_a[r][0] * r_e[r][0]) : 32'sd0;
                r_prod[r][3][0][1] <= use_a ? -(r_a[r][1] * r_e[r][1]) : 32'sd0;
                r_prod[r][3][1][0] <= use_a ? r_a[r][1] * r_e[r][0] : 32'sd0;
                r_prod[r][3][1][1] <= use_a ? -(r_a[r][0] * r_e[r][1]) : 32'sd0;
            end
            r_fault1 <= (r_p0 == '0) || (r_p1 == '0);
            r_p0_1 <= (r_p0 == '0) ? smu_pkg::POW_W'(1) : r_p0;
            r_p1_1 <= (r_p1 == '0) ? smu_pkg::POW_W'(1) : r_p1;
        end
    end

    // Stage 2: sums of four products each.
    logic signed [SW-1:0] r_sum [4][2];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < 4; s++) begin
                for (int q = 0; q < 2; q++) begin
                    r_sum[s][q] <= SW'(r_prod[0][s][q][0]) + SW'(r_prod[0][s][q][1])
                                 + SW'(r_prod[1][s][q][0]) + SW'(r_prod[1][s][q][1]);
                end
            end
        end
    end

    // Reciprocal pipeline: stage 3+k produces quotient bit 30-k of 2^30 / P.
    // The sums ride along one entry behind the quotient: r_dsum[k] pairs with r_q0[k+1].
    localparam int NS = smu_pkg::DIV_STEPS;
    logic [smu_pkg::POW_W:0] r_rem0 [NS+1];
    logic [smu_pkg::POW_W:0] r_rem1 [NS+1];
    logic [RW-1:0]           r_q0   [NS+1];
    logic [RW-1:0]           r_q1   [NS+1];
    logic [smu_pkg::POW_W-1:0] r_dv0 [NS+1];
    logic [smu_pkg::POW_W-1:0] r_dv1 [NS+1];
    logic signed [SW-1:0]    r_dsum [NS][4][2];
    logic                    r_dflt [NS+1];

    // Dividend bit stream: only bit 30 is one, so each step shifts in zero
    // except the first, which starts with a one.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem0[0] <= '0;
            r_rem1[0] <= '0;
            r_q0[0]   <= '0;
            r_q1[0]   <= '0;
            r_dv0[0]  <= r_p0_1;
            r_dv1[0]  <= r_p1_1;
            r_dflt[0] <= r_fault1;
            for (int k = 0; k < NS; k++) begin
                logic [smu_pkg::POW_W:0] t0;
                logic [smu_pkg::POW_W:0] t1;
                t0 = {r_rem0[k][smu_pkg::POW_W-1:0], (k == 0)};
                t1 = {r_rem1[k][smu_pkg::POW_W-1:0], (k == 0)};
                if (t0 >= {1'b0, r_dv0[k]}) begin
                    r_rem0[k+1] <= t0 - {1'b0, r_dv0[k]};
                    r_q0[k+1]   <= {r_q0[k][RW-2:0], 1'b1};
                end else begin
                    r_rem0[k+1] <= t0;
                    r_q0[k+1]   <= {r_q0[k][RW-2:0], 1'b0};
                end
                if (t1 >= {1'b0, r_dv1[k]}) begin
                    r_rem1[k+1] <= t1 - {1'b0, r_dv1[k]};
                    r_q1[k+1]   <= {r_q1[k][RW-2:0], 1'b1};
                end else begin
                    r_rem1[k+1] <= t1;
                    r_q1[k+1]   <= {r_q1[k][RW-2:0], 1'b0};
                end
                r_dv0[k+1]  <= r_dv0[k];
                r_dv1[k+1]  <= r_dv1[k];
                r_dflt[k+1] <= r_dflt[k];
            end
            for (int k = 0; k < NS-1; k++) begin
                r_dsum[k+1] <= r_dsum[k];
            end
            r_dsum[0] <= r_sum;
        end
    end

    // Scale stage: eight products sum * reciprocal.
    logic signed [smu_pkg::PROD_W-1:0] r_scl [4][2];
    logic r_fault_s;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < 4; s++) begin
                for (int q = 0; q < 2; q++) begin
                    // s00 and s10 use 1/P0, s11 and s01 use 1/P1.
                    if (s == 0 || s == 3) begin
                        r_scl[s][q] <= smu_pkg::PROD_W'(r_dsum[NS-1][s][q])
                                     * $signed({1'b0, r_q0[NS]});
                    end else begin
                        r_scl[s][q] <= smu_pkg::PROD_W'(r_dsum[NS-1][s][q])
                                     * $signed({1'b0, r_q1[NS]});
                    end
                end
            end
            r_fault_s <= r_dflt[NS];
        end
    end

    // Round stage: floor((x + 2^32) >> 33) per term and sum of term pairs.
    localparam int TW = smu_pkg::TERM_W;
    logic signed [TW:0] r_lane [2][2];
    logic r_fault_r;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int q = 0; q < 2; q++) begin
                logic signed [smu_pkg::PROD_W-1:0] t00, t01, t11, t10;
                t00 = (r_scl[0][q] + (smu_pkg::PROD_W'(1) <<< 32)) >>> 33;
                t01 = (r_scl[2][q] + (smu_pkg::PROD_W'(1) <<< 32)) >>> 33;
                t11 = (r_scl[1][q] + (smu_pkg::PROD_W'(1) <<< 32)) >>> 33;
                t10 = (r_scl[3][q] + (smu_pkg::PROD_W'(1) <<< 32)) >>> 33;
                r_lane[0][q] <= (TW+1)'(t00) + (TW+1)'(t01);
                r_lane[1][q] <= (TW+1)'(t11) + (TW+1)'(t10);
            end
            r_fault_r <= r_fault_s;
        end
    end

    // Output stage: saturation and fault forcing.
    smu_pkg::t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_fault_r) begin
                r_out <= '{out_k0: '0, out_k1: '0, recip_fault: 1'b1};
            end else begin
                r_out <= '{out_k0: {smu_pkg::sat_lane(r_lane[0][0]),
                                    smu_pkg::sat_lane(r_lane[0][1])},
                           out_k1: {smu_pkg::sat_lane(r_lane[1][0]),
                                    smu_pkg::sat_lane(r_lane[1][1])},
                           recip_fault: 1'b0};
            end
        end
    end
    assign o_data = r_out;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("output item changed under stall");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output stage");
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.recip_fault) |-> (o_data.out_k0 == '0 && o_data.out_k1 == '0))
        else $error("fault item carries nonzero data");
`endif

endmodule

// ----- test/sfbc_mrc_unprecoder_unit_tb.sv -----
// Testbench of the SFBC / MRC combining unit: directed table, random items, scoreboard.
`timescale 1ns / 1ps

module sfbc_mrc_unprecoder_unit_tb;

    localparam int N_RANDOM  = 1250;
    localparam int WDOG_MAX  = 20000;
    localparam int LATENCY   = 37;
    localparam int N_DIRECT  = 14;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    smu_pkg::t_in_item   i_data;
    logic                o_valid;
    logic                i_stall;
    smu_pkg::t_out_item  o_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    sfbc_mrc_unprecoder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the antenna registers.
    logic [1:0] model_tx_ant;
    logic [1:0] model_rx_ant;

    smu_pkg::t_out_item  decoded_q[$];
    int         err_count;
    int         idle_cycles;
    bit         sink_quiet;
    bit         hold_off_req;
    bit         src_quiet;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] lane_of(input logic [63:0] w, input int sh);
        logic [15:0] v;
        v = w[sh +: 16];
        return 64'(signed'(v));
    endfunction

    function automatic logic signed [63:0] round_term(input logic signed [63:0] s,
                                                      input logic signed [63:0] r);
        logic signed [127:0] p;
        p = 128'(s) * 128'(r) + (128'sd1 <<< 32);
        return 64'(p >>> 33);
    endfunction

    function automatic logic [15:0] clip_lane(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (smu_pkg::LANE_SAT_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[15:0];
    endfunction

    function automatic smu_pkg::t_out_item decode_pair(input smu_pkg::t_in_item it);
        smu_pkg::t_out_item res;
        logic [16:0]        p0;
        logic [16:0]        p1;
        logic signed [63:0] s00r, s00i, s01r, s01i, s11r, s11i, s10r, s10i;
        logic signed [63:0] ar, ai, br, bi, cr, ci, fr, fi, er, ei, dr, di;
        logic signed [63:0] r0, r1;
        logic [63:0]        x, h0, h1;
        int                 nrx;
        bit                 alam;
        alam = (model_tx_ant == smu_pkg::ANT_TWO);
        nrx  = (model_rx_ant == smu_pkg::ANT_TWO) ? 2 : 1;
        p0 = 17'(it.power_words[63:48]);
        p1 = 17'(it.power_words[47:32]);
        if (nrx == 2) begin
            p0 += 17'(it.power_words[31:16]);
            p1 += 17'(it.power_words[15:0]);
        end
        res = '0;
        if (p0 == 0 || p1 == 0) begin
            res.recip_fault = 1'b1;
            return res;
        end
        {s00r, s00i, s01r, s01i, s11r, s11i, s10r, s10i} = '0;
        for (int r = 0; r < nrx; r++) begin
            x  = (r == 0) ? it.rx0_pair : it.rx1_pair;
            h0 = (r == 0) ? it.ch_r0_t0_pair : it.ch_r1_t0_pair;
            h1 = (r == 0) ? it.ch_r0_t1_pair : it.ch_r1_t1_pair;
            ar = lane_of(x, 48);  ai = lane_of(x, 32);
            br = lane_of(x, 16);  bi = lane_of(x, 0);
            cr = lane_of(h0, 48); ci = lane_of(h0, 32);
            fr = lane_of(h0, 16); fi = lane_of(h0, 0);
            er = lane_of(h1, 48); ei = lane_of(h1, 32);
            dr = lane_of(h1, 16); di = lane_of(h1, 0);
            s00r += ar * cr + ai * ci;
            s00i += ai * cr - ar * ci;
            s11r += br * fr + bi * fi;
            s11i += bi * fr - br * fi;
            if (alam) begin
                s01r += br * dr + bi * di;
                s01i += br * di - bi * dr;
                s10r -= ar * er + ai * ei;
                s10i += ai * er - ar * ei;
            end
        end
        r0 = 64'((64'd1 << 30) / 64'(p0));
        r1 = 64'((64'd1 << 30) / 64'(p1));
        res.out_k0 = {clip_lane(round_term(s00r, r0) + round_term(s01r, r1)),
                      clip_lane(round_term(s00i, r0) + round_term(s01i, r1))};
        res.out_k1 = {clip_lane(round_term(s11r, r1) + round_term(s10r, r0)),
                      clip_lane(round_term(s11i, r1) + round_term(s10i, r0))};
        return res;
    endfunction

    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 3'(idx) << 2; pwdata = 32'(val);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx == smu_pkg::REG_TX_ANT) model_tx_ant = val;
        else model_rx_ant = val;
    endtask

    task automatic send_item(input smu_pkg::t_in_item it, input bit use_table,
                             input smu_pkg::t_out_item table_res);
        smu_pkg::t_out_item predicted;
        predicted = decode_pair(it);
        if (use_table && predicted !== table_res) begin
            $error("table row disagrees with predictor: exp %h got %h", table_res, predicted);
            err_count++;
        end
        while (!src_quiet && $urandom_range(99) < 29) @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = it;
        do @(posedge i_clk); while (o_stall);
        decoded_q.push_back(predicted);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic smu_pkg::t_in_item rand_item();
        smu_pkg::t_in_item it;
        logic [15:0] s [0:23];
        for (int k = 0; k < 24; k++) s[k] = rand_sample();
        it.rx0_pair      = {s[0], s[1], s[2], s[3]};
        it.rx1_pair      = {s[4], s[5], s[6], s[7]};
        it.ch_r0_t0_pair = {s[8], s[9], s[10], s[11]};
        it.ch_r0_t1_pair = {s[12], s[13], s[14], s[15]};
        it.ch_r1_t0_pair = {s[16], s[17], s[18], s[19]};
        it.ch_r1_t1_pair = {s[20], s[21], s[22], s[23]};
        case ($urandom_range(9))
            0: it.power_words = rand64() & 64'h0000_FFFF_FFFF_FFFF;
            1: it.power_words = 64'hFFFF_FFFF_FFFF_FFFF;
            2: it.power_words = {16'd1, 16'd1, 16'($urandom), 16'($urandom)};
            default: it.power_words = rand64();
        endcase
        return it;
    endfunction

    // Directed rows: powers and samples at their extremes, plus zero power; the last rows are random items.
    smu_pkg::t_in_item  dir_items [N_DIRECT];
    smu_pkg::t_out_item dir_res   [N_DIRECT];
    bit                 dir_known [N_DIRECT];

    initial begin
        for (int k = 0; k < N_DIRECT; k++) begin
            dir_items[k] = '0; dir_res[k] = '0; dir_known[k] = 1'b0;
        end
        // Zero power at k0: fault, zero outputs.
        dir_items[0].rx0_pair = 64'h1234_5678_9ABC_DEF0;
        dir_items[0].power_words = 64'h0000_1000_1000_1000;
        dir_res[0].recip_fault = 1'b1; dir_known[0] = 1'b1;
        // Zero power at k1.
        dir_items[1].power_words = 64'h1000_0000_FFFF_FFFF;
        dir_res[1].recip_fault = 1'b1; dir_known[1] = 1'b1;
        // Zero symbols with power: zero outputs, no fault.
        dir_items[2].power_words = 64'h1000_1000_1000_1000;
        dir_known[2] = 1'b1;
        // Most negative samples with minimum power: saturate high.
        dir_items[3].rx0_pair      = 64'h8000_8000_8000_8000;
        dir_items[3].ch_r0_t0_pair = 64'h8000_8000_8000_8000;
        dir_items[3].power_words   = 64'h0001_0001_0000_0000;
        dir_res[3].out_k0 = 32'h7FFF_0000; dir_res[3].out_k1 = 32'h7FFF_0000;
        dir_known[3] = 1'b1;
        // Largest positive symbols against a negative channel: saturate low.
        dir_items[4].rx0_pair      = 64'h7FFF_0000_7FFF_0000;
        dir_items[4].ch_r0_t0_pair = 64'h8000_0000_8000_0000;
        dir_items[4].power_words   = 64'h0001_0001_0000_0000;
        dir_res[4].out_k0 = 32'h8000_0000; dir_res[4].out_k1 = 32'h8000_0000;
        dir_known[4] = 1'b1;
        // Unity symbol, unity channel, unity power: 1.0 at the output.
        dir_items[5].rx0_pair      = 64'h2000_0000_2000_0000;
        dir_items[5].ch_r0_t0_pair = 64'h2000_0000_2000_0000;
        dir_items[5].power_words   = 64'h1000_1000_0000_0000;
        dir_res[5].out_k0 = 32'h0800_0000; dir_res[5].out_k1 = 32'h0800_0000;
        dir_known[5] = 1'b1;
        dir_items[6].power_words = 64'hFFFF_FFFF_FFFF_FFFF;
        dir_items[6].rx0_pair = 64'h7FFF_7FFF_7FFF_7FFF;
        dir_items[6].ch_r0_t0_pair = 64'h7FFF_8000_7FFF_8000;
        for (int k = 7; k < N_DIRECT; k++) dir_items[k] = rand_item();
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall = 1'b1;
                for (hold = 0; hold < 120; hold++) @(negedge i_clk);
            end
            i_stall = !sink_quiet && ($urandom_range(99) < 29);
        end
    end

    // Scoreboard on the output channel.
    initial begin
        smu_pkg::t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result %h", o_data);
                    err_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_data.out_k0 !== want.out_k0) begin
                        $error("out_k0 exp %h got %h", want.out_k0, o_data.out_k0);
                        err_count++;
                    end
                    if (o_data.out_k1 !== want.out_k1) begin
                        $error("out_k1 exp %h got %h", want.out_k1, o_data.out_k1);
                        err_count++;
                    end
                    if (o_data.recip_fault !== want.recip_fault) begin
                        $error("recip_fault exp %b got %b", want.recip_fault,
                               o_data.recip_fault);
                        err_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item on either side and without APB select.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic drain();
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0] ant_sets [6][2];
        ant_sets = '{'{2'd1, 2'd1}, '{2'd2, 2'd2}, '{2'd2, 2'd1},
                     '{2'd1, 2'd2}, '{2'd0, 2'd3}, '{2'd3, 2'd0}};
        err_count = 0; sink_quiet = 1'b0; src_quiet = 1'b0; hold_off_req = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        model_tx_ant = 2'd1; model_rx_ant = 2'd1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows after reset, both antenna registers at one.
        for (int k = 0; k < N_DIRECT; k++) send_item(dir_items[k], dir_known[k], dir_res[k]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(smu_pkg::REG_TX_ANT, ant_sets[ph][0]);
            write_reg(smu_pkg::REG_RX_ANT, ant_sets[ph][1]);
            // Rerun a few directed rows under each setting.
            for (int k = 2; k < 7; k++) send_item(dir_items[k], 1'b0, '0);
            if (ph == 1) begin
                hold_off_req = 1'b1;
                src_quiet = 1'b1;
            end
            if (ph == 2) sink_quiet = 1'b1;
            for (int n = 0; n < N_RANDOM / 6; n++) send_item(rand_item(), 1'b0, '0);
            src_quiet = 1'b0; sink_quiet = 1'b0;
            drain();
        end

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sfbc_mrc_unprecoder_unit.f -----
rtl/core/smu_pkg.sv
rtl/core/sfbc_mrc_unprecoder_unit.sv
test/sfbc_mrc_unprecoder_unit_tb.sv
